### rtl/edts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edts_pkg
// Shared types and constants for the earliest-deadline task scheduler.
// ----------------------------------------------------------------------------
package edts_pkg;

  localparam int unsigned DefMaxTasks = 16;
  localparam int unsigned DefTimeBits = 16;

  localparam int unsigned FieldTimeW = 16;
  localparam int unsigned WorkW      = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned CountW     = 5;
  localparam int unsigned OpW        = 2;

  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } edts_op_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // write one task entry
    logic clear;      // zero the time counter
    logic plain_res;  // emit a result word with no task info
    logic scan_init;  // latch limit, clear best-so-far
    logic rd_en;      // read entry at scan index, advance index
    logic commit;     // write back the pick, emit tick result, advance time
  } edts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // current scan index is the last one below the limit
    logic limit_zero; // no entries take part
  } edts_stat_t;

endpackage
`default_nettype wire

### rtl/edts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edts_ctrl
// Sequencer: decodes accepted words and steps the datapath through the
// per-tick scan, compare drain and write-back.
// ----------------------------------------------------------------------------
module edts_ctrl
  import edts_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic [OpW-1:0] opcode_i,
  input  wire edts_stat_t     stat_i,
  output edts_cmd_t           cmd_o,
  output logic                busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   accept;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_TICK) begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end else begin
            cmd_o.plain_res = 1'b1;
            cmd_o.load      = (opcode_i == OP_LOAD);
            cmd_o.clear     = (opcode_i == OP_CLEAR);
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = !stat_i.limit_zero;
        if (stat_i.limit_zero || stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // last read word is compared here
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

endmodule
`default_nettype wire

### rtl/edts_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edts_dp
// Datapath: task entry memories, time counter, one-entry-per-cycle
// earliest-deadline compare and the result word registers.
// ----------------------------------------------------------------------------
module edts_dp
  import edts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = DefMaxTasks,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire edts_cmd_t             cmd_i,
  output edts_stat_t                 stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CountW-1:0]     cfg_wdata_i,
  input  wire logic [SlotW-1:0]      task_slot_i,
  input  wire logic [FieldTimeW-1:0] arrival_time_i,
  input  wire logic [WorkW-1:0]      work_ticks_i,
  input  wire logic [FieldTimeW-1:0] deadline_time_i,
  input  wire logic                  deadline_present_i,
  output logic                       result_valid_o,
  output logic                       task_ran_o,
  output logic [SlotW-1:0]           chosen_task_o,
  output logic                       task_done_o,
  output logic [FieldTimeW-1:0]      finish_tick_o,
  output logic [FieldTimeW-1:0]      turnaround_o,
  output logic [FieldTimeW-1:0]      tick_time_o
);

  localparam int unsigned IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam int unsigned ExtW = TIME_BITS + FieldTimeW;

  // entry memories
  logic [TIME_BITS-1:0] arr_mem  [MAX_TASKS];
  logic [TIME_BITS-1:0] dl_mem   [MAX_TASKS];
  logic                 dv_mem   [MAX_TASKS];
  logic [WorkW-1:0]     work_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] live_q;   // entry loaded since reset

  logic [CountW-1:0]    task_count_q;
  logic [TIME_BITS-1:0] now_q;

  // scan state
  logic [CntW-1:0] scan_idx_q, limit_q;
  logic [IdxW-1:0] rd_addr;

  // read stage
  logic                 rd_valid_q;
  logic [IdxW-1:0]      rd_idx_q;
  logic [TIME_BITS-1:0] rd_arr_q, rd_dl_q;
  logic                 rd_dv_q, rd_live_q;
  logic [WorkW-1:0]     rd_work_q;

  // best so far
  logic                 found_q;
  logic [IdxW-1:0]      best_idx_q;
  logic [TIME_BITS-1:0] best_arr_q, best_dl_q;
  logic                 best_dv_q;
  logic [WorkW-1:0]     best_work_q;

  // result word
  logic                 res_valid_q, res_ran_q, res_done_q;
  logic [IdxW-1:0]      res_idx_q;
  logic [TIME_BITS-1:0] res_fin_q, res_turn_q, res_stamp_q;

  // input conversion
  logic [ExtW-1:0]       arr_ext, dl_ext;
  logic [TIME_BITS-1:0]  arr_in, dl_in;
  logic                  slot_ok;
  logic [IdxW+SlotW-1:0] slot_ext;
  logic [IdxW-1:0]       slot_idx;
  logic [CntW+CountW-1:0] tc_ext, max_ext;
  logic [CntW+CountW-1:0] limit_ext;

  assign arr_ext  = {{TIME_BITS{1'b0}}, arrival_time_i};
  assign dl_ext   = {{TIME_BITS{1'b0}}, deadline_time_i};
  assign arr_in   = arr_ext[TIME_BITS-1:0];
  assign dl_in    = dl_ext[TIME_BITS-1:0];
  assign slot_ok  = ({28'd0, task_slot_i} < 32'(MAX_TASKS));
  assign slot_ext = {{IdxW{1'b0}}, task_slot_i};
  assign slot_idx = slot_ext[IdxW-1:0];

  assign tc_ext    = {{CntW{1'b0}}, task_count_q};
  assign max_ext   = (CntW + CountW)'(MAX_TASKS);
  assign limit_ext = (tc_ext > max_ext) ? max_ext : tc_ext;

  assign rd_addr = scan_idx_q[IdxW-1:0];

  assign stat_o.limit_zero = (limit_q == '0);
  assign stat_o.scan_last  = ((scan_idx_q + CntW'(1)) >= limit_q);

  // compare stage
  logic cand, take;
  assign cand = rd_valid_q && rd_live_q && rd_dv_q && (rd_work_q != '0)
                && (rd_arr_q <= now_q);
  assign take = cand && (!found_q || (rd_dl_q < best_dl_q));

  // write port: load or write-back of the picked task
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [TIME_BITS-1:0] wr_arr, wr_dl;
  logic                 wr_dv;
  logic [WorkW-1:0]     wr_work;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx_q;
    wr_arr  = best_arr_q;
    wr_dl   = best_dl_q;
    wr_dv   = best_dv_q;
    wr_work = best_work_q - WorkW'(1);
    if (cmd_i.load) begin
      wr_en   = slot_ok;
      wr_addr = slot_idx;
      wr_arr  = arr_in;
      wr_dl   = dl_in;
      wr_dv   = deadline_present_i;
      wr_work = work_ticks_i;
    end else if (cmd_i.commit) begin
      wr_en = found_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      arr_mem[wr_addr]  <= wr_arr;
      dl_mem[wr_addr]   <= wr_dl;
      dv_mem[wr_addr]   <= wr_dv;
      work_mem[wr_addr] <= wr_work;
    end
    if (cmd_i.rd_en) begin
      rd_arr_q  <= arr_mem[rd_addr];
      rd_dl_q   <= dl_mem[rd_addr];
      rd_dv_q   <= dv_mem[rd_addr];
      rd_work_q <= work_mem[rd_addr];
      rd_live_q <= live_q[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  // best-so-far payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q  <= rd_idx_q;
      best_arr_q  <= rd_arr_q;
      best_dl_q   <= rd_dl_q;
      best_dv_q   <= rd_dv_q;
      best_work_q <= rd_work_q;
    end
  end

  logic [TIME_BITS-1:0] now_inc;
  logic                 fin_hit;
  assign now_inc = now_q + TIME_BITS'(1);
  assign fin_hit = found_q && (best_work_q == WorkW'(1));

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.plain_res) begin
      res_ran_q   <= 1'b0;
      res_idx_q   <= '0;
      res_done_q  <= 1'b0;
      res_fin_q   <= '0;
      res_turn_q  <= '0;
      res_stamp_q <= cmd_i.clear ? '0 : now_q;
    end else if (cmd_i.commit) begin
      res_ran_q   <= found_q;
      res_idx_q   <= found_q ? best_idx_q : '0;
      res_done_q  <= fin_hit;
      res_fin_q   <= fin_hit ? now_inc : '0;
      res_turn_q  <= fin_hit ? (now_inc - best_arr_q) : '0;
      res_stamp_q <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
      now_q        <= '0;
      live_q       <= '0;
      scan_idx_q   <= '0;
      limit_q      <= '0;
      rd_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        task_count_q <= cfg_wdata_i;
      end
      if (cmd_i.load && slot_ok) begin
        live_q[slot_idx] <= 1'b1;
      end
      if (cmd_i.clear) begin
        now_q <= '0;
      end else if (cmd_i.commit) begin
        now_q <= now_inc;
      end
      if (cmd_i.scan_init) begin
        scan_idx_q <= '0;
        limit_q    <= limit_ext[CntW-1:0];
      end else if (cmd_i.rd_en) begin
        scan_idx_q <= scan_idx_q + CntW'(1);
      end
      rd_valid_q <= cmd_i.rd_en;
      if (cmd_i.scan_init) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
      res_valid_q <= cmd_i.plain_res || cmd_i.commit;
    end
  end

  // output widths
  logic [ExtW-1:0]       fin_ext, turn_ext, stamp_ext;
  logic [IdxW+SlotW-1:0] idx_ext;
  assign fin_ext   = {{FieldTimeW{1'b0}}, res_fin_q};
  assign turn_ext  = {{FieldTimeW{1'b0}}, res_turn_q};
  assign stamp_ext = {{FieldTimeW{1'b0}}, res_stamp_q};
  assign idx_ext   = {{SlotW{1'b0}}, res_idx_q};

  assign result_valid_o = res_valid_q;
  assign task_ran_o     = res_ran_q;
  assign chosen_task_o  = idx_ext[SlotW-1:0];
  assign task_done_o    = res_done_q;
  assign finish_tick_o  = fin_ext[FieldTimeW-1:0];
  assign turnaround_o   = turn_ext[FieldTimeW-1:0];
  assign tick_time_o    = stamp_ext[FieldTimeW-1:0];

endmodule
`default_nettype wire

### rtl/earliest_deadline_task_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// earliest_deadline_task_scheduler
// Preemptive earliest-deadline-first scheduler driven by tick words.
//
//   channel   handshake                  payload
//   -------   -------------------------  ----------------------------------
//   command   start & !busy              opcode, task_slot, arrival_time,
//                                        work_ticks, deadline_time,
//                                        deadline_present
//   result    result_valid_o (1 cycle)   task_ran, chosen_task, task_done,
//                                        finish_tick, turnaround, tick_time
//   config    cfg_we_i                   cfg_wdata_i -> task_count
//
// Load and clear words: result strobe the cycle after accept, busy stays low,
// so one word per cycle. Tick words: one shared comparator reads one task
// entry per cycle over the first min(task_count, MAX_TASKS) entries; after
// the drain and commit states the result strobes and the next word is taken.
// Reset clears time, task_count and the per-entry loaded bits; no sweep.
// The receiver cannot stall; every result is valid for one cycle.
// ----------------------------------------------------------------------------
module earliest_deadline_task_scheduler
  import edts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = DefMaxTasks,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CountW-1:0]     cfg_wdata_i,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [OpW-1:0]        opcode_i,
  input  wire logic [SlotW-1:0]      task_slot_i,
  input  wire logic [FieldTimeW-1:0] arrival_time_i,
  input  wire logic [WorkW-1:0]      work_ticks_i,
  input  wire logic [FieldTimeW-1:0] deadline_time_i,
  input  wire logic                  deadline_present_i,
  output logic                       result_valid_o,
  output logic                       task_ran_o,
  output logic [SlotW-1:0]           chosen_task_o,
  output logic                       task_done_o,
  output logic [FieldTimeW-1:0]      finish_tick_o,
  output logic [FieldTimeW-1:0]      turnaround_o,
  output logic [FieldTimeW-1:0]      tick_time_o
);

  edts_cmd_t  cmd;
  edts_stat_t stat;

  edts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  edts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .task_slot_i        (task_slot_i),
    .arrival_time_i     (arrival_time_i),
    .work_ticks_i       (work_ticks_i),
    .deadline_time_i    (deadline_time_i),
    .deadline_present_i (deadline_present_i),
    .result_valid_o     (result_valid_o),
    .task_ran_o         (task_ran_o),
    .chosen_task_o      (chosen_task_o),
    .task_done_o        (task_done_o),
    .finish_tick_o      (finish_tick_o),
    .turnaround_o       (turnaround_o),
    .tick_time_o        (tick_time_o)
  );

endmodule
`default_nettype wire
